[rtl/dmc_pkg.sv]
// Shared types, constants and helper functions for the DFS maze carver.
// Used by dmc_nbr, dfs_maze_carver_top and the testbench; depends on nothing else.
`default_nettype none

package dmc_pkg;

   // Grid geometry: sides up to MAX_SIDE, odd cells packed as {row/2, col/2}
   localparam int MAX_SIDE  = 63;
   localparam int HALF_SIDE = (MAX_SIDE + 1) / 2;
   localparam int HALF_W    = $clog2(HALF_SIDE);
   localparam int SIDE_W    = HALF_W + 1;
   localparam int CELL_W    = 2 * HALF_W;
   localparam int CELL_SLOTS = HALF_SIDE * HALF_SIDE;

   // Default stack depth handed to the top level
   localparam int STACK_DEPTH_DEF = 1024;

   // Field widths of the channels
   localparam int PERM_W  = 5;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   // Reset values of the requested sides
   localparam logic [SIDE_W-1:0] ROWS_REQ_RST = 6'd21;
   localparam logic [SIDE_W-1:0] COLS_REQ_RST = 6'd41;
   localparam logic [SIDE_W-1:0] SIDE_MIN     = 6'd3;

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_LEFT,
      DIR_DOWN,
      DIR_UP
   } dir_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_POP,
      ST_TOP,
      ST_LOOK,
      ST_TEST,
      ST_PUSH_CUR,
      ST_PUSH_NEW,
      ST_SEND
   } state_type;

   // Result of one neighbor probe
   typedef struct packed {
      logic              ok;
      logic [SIDE_W-1:0] wall_row;
      logic [SIDE_W-1:0] wall_col;
      logic [SIDE_W-1:0] nb_row;
      logic [SIDE_W-1:0] nb_col;
      logic [CELL_W-1:0] idx;
   } nbr_res_type;

   // Round a requested side up to odd and at least three
   function automatic logic [SIDE_W-1:0] side_fix(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v < SIDE_MIN) begin
         r = SIDE_MIN;
      end else begin
         r = v | SIDE_W'(1);
      end
      return r;
   endfunction

   // Lexicographic permutation of right, left, down, up; first direction in [7:6]
   function automatic logic [7:0] perm_order(input logic [PERM_W-1:0] p);
      logic [7:0] w;
      case (p)
         5'd0:    w = 8'h1B;
         5'd1:    w = 8'h1E;
         5'd2:    w = 8'h27;
         5'd3:    w = 8'h2D;
         5'd4:    w = 8'h36;
         5'd5:    w = 8'h39;
         5'd6:    w = 8'h4B;
         5'd7:    w = 8'h4E;
         5'd8:    w = 8'h63;
         5'd9:    w = 8'h6C;
         5'd10:   w = 8'h72;
         5'd11:   w = 8'h78;
         5'd12:   w = 8'h87;
         5'd13:   w = 8'h8D;
         5'd14:   w = 8'h93;
         5'd15:   w = 8'h9C;
         5'd16:   w = 8'hB1;
         5'd17:   w = 8'hB4;
         5'd18:   w = 8'hC6;
         5'd19:   w = 8'hC9;
         5'd20:   w = 8'hD2;
         5'd21:   w = 8'hD8;
         5'd22:   w = 8'hE1;
         5'd23:   w = 8'hE4;
         default: w = 8'h1B;
      endcase
      return w;
   endfunction

   // Pick the direction tried at position k of an order word
   function automatic dir_type dir_pick(input logic [7:0] w, input logic [1:0] k);
      dir_type d;
      case (k)
         2'd0:    d = dir_type'(w[7:6]);
         2'd1:    d = dir_type'(w[5:4]);
         2'd2:    d = dir_type'(w[3:2]);
         2'd3:    d = dir_type'(w[1:0]);
         default: d = DIR_RIGHT;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/dfs_maze_carver_top.sv]
// Top level of the randomized depth-first maze carver: sequencer, probe
// unit, visited-map and cell-stack memories. Depends on dmc_pkg, dmc_ram, dmc_nbr.
//
// One item at a time: req_ready is high only while the block is idle, and it
// drops until every result of the item has been taken on the rsp channel.
// A start (cmd 0) sweeps all CELL_SLOTS (1024) entries of the visited map,
// one entry per cycle, then marks and pushes cell (1,1) before its result
// appears. A step on a non-empty stack pops the top cell, then probes one
// direction at a time (one visited-map read through the probe unit per
// direction, at most four), and makes the two stack pushes when it carves.
// A step on an empty stack goes straight to its result. Each result then
// needs at least one cycle on rsp. Grid sizes written over the csr port take
// effect at the next start; csr writes are always accepted.
`default_nettype none

module dfs_maze_carver_top #(
   parameter int STACK_DEPTH = dmc_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_cmd,
   input  wire logic [dmc_pkg::PERM_W-1:0]        req_perm,
   // result items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_carved,
   output logic [dmc_pkg::SIDE_W-1:0]             rsp_cell_row,
   output logic [dmc_pkg::SIDE_W-1:0]             rsp_cell_col,
   output logic                                   rsp_last,
   output logic                                   rsp_done_res,
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dmc_pkg::SIDE_W-1:0]        csr_data
);
   import dmc_pkg::*;

   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int SADDR_W = $clog2(STACK_DEPTH);

   // control registers
   state_type         state_ff, state_in;
   logic [SIDE_W-1:0] rows_req_ff, rows_req_in;
   logic [SIDE_W-1:0] cols_req_ff, cols_req_in;
   logic [SIDE_W-1:0] rows_used_ff, rows_used_in;
   logic [SIDE_W-1:0] cols_used_ff, cols_used_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              sec_pend_ff, sec_pend_in;

   // payload registers
   logic [CELL_W-1:0] clr_ff, clr_in;
   logic [PERM_W-1:0] perm_ff, perm_in;
   logic [CELL_W-1:0] top_ff, top_in;
   logic [1:0]        dir_idx_ff, dir_idx_in;
   nbr_res_type       nbr_ff, nbr_in;
   logic              carved_ff, carved_in;
   logic [SIDE_W-1:0] row_ff, row_in;
   logic [SIDE_W-1:0] col_ff, col_in;
   logic              last_ff, last_in;
   logic              done_ff, done_in;
   logic [SIDE_W-1:0] sec_row_ff, sec_row_in;
   logic [SIDE_W-1:0] sec_col_ff, sec_col_in;

   // memory ports
   logic               vis_wr_en;
   logic [CELL_W-1:0]  vis_wr_addr;
   logic               vis_wr_data;
   logic               vis_rd_en;
   logic               vis_rd_data;
   logic               stk_wr_en;
   logic [SADDR_W-1:0] stk_wr_addr;
   logic [CELL_W-1:0]  stk_wr_data;
   logic               stk_rd_en;
   logic [SADDR_W-1:0] stk_rd_addr;
   logic [CELL_W-1:0]  stk_rd_data;

   // helpers
   logic              req_fire;
   logic              rsp_fire;
   logic              stk_has_room;
   logic [CNT_W-1:0]  count_dec;
   logic              clr_last;
   logic              found;
   dir_type           cur_dir;
   nbr_res_type       probe;
   logic [SIDE_W-1:0] top_row;
   logic [SIDE_W-1:0] top_col;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_SEND);
   assign csr_ready    = 1'b1;
   assign req_fire     = req_valid && req_ready;
   assign rsp_fire     = rsp_valid && rsp_ready;
   assign stk_has_room = (count_ff < CNT_W'(STACK_DEPTH));
   assign count_dec    = count_ff - CNT_W'(1);
   assign clr_last     = (clr_ff == CELL_W'(CELL_SLOTS - 1));
   assign found        = nbr_ff.ok && !vis_rd_data;
   assign cur_dir      = dir_pick(perm_order(perm_ff), dir_idx_ff);
   assign top_row      = {top_ff[CELL_W-1:HALF_W], 1'b1};
   assign top_col      = {top_ff[HALF_W-1:0], 1'b1};

   assign rsp_carved   = carved_ff;
   assign rsp_cell_row = row_ff;
   assign rsp_cell_col = col_ff;
   assign rsp_last     = last_ff;
   assign rsp_done_res = done_ff;

   // shared probe unit, one direction per look
   dmc_nbr u_nbr (
      .cur_row   (top_row),
      .cur_col   (top_col),
      .dir       (cur_dir),
      .rows_used (rows_used_ff),
      .cols_used (cols_used_ff),
      .res       (probe)
   );

   dmc_ram #(.WIDTH(1), .DEPTH(CELL_SLOTS)) u_visited (
      .clock   (clock),
      .wr_en   (vis_wr_en),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_en   (vis_rd_en),
      .rd_addr (probe.idx),
      .rd_data (vis_rd_data)
   );

   dmc_ram #(.WIDTH(CELL_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_START) begin
                  state_in = ST_CLEAR;
               end else if (count_ff == '0) begin
                  state_in = ST_SEND;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED:     state_in = ST_SEND;
         ST_POP:      state_in = ST_TOP;
         ST_TOP:      state_in = ST_LOOK;
         ST_LOOK:     state_in = ST_TEST;
         ST_TEST: begin
            if (found) begin
               state_in = ST_PUSH_CUR;
            end else if (dir_idx_ff == 2'd3) begin
               state_in = ST_SEND;
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_PUSH_CUR: state_in = ST_PUSH_NEW;
         ST_PUSH_NEW: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_fire && !sec_pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath, memory controls and result loading
   always_comb begin
      rows_req_in  = rows_req_ff;
      cols_req_in  = cols_req_ff;
      rows_used_in = rows_used_ff;
      cols_used_in = cols_used_ff;
      count_in     = count_ff;
      sec_pend_in  = sec_pend_ff;
      clr_in       = clr_ff;
      perm_in      = perm_ff;
      top_in       = top_ff;
      dir_idx_in   = dir_idx_ff;
      nbr_in       = nbr_ff;
      carved_in    = carved_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      sec_row_in   = sec_row_ff;
      sec_col_in   = sec_col_ff;
      vis_wr_en    = 1'b0;
      vis_wr_addr  = clr_ff;
      vis_wr_data  = 1'b0;
      vis_rd_en    = 1'b0;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = count_ff[SADDR_W-1:0];
      stk_wr_data  = top_ff;
      stk_rd_en    = 1'b0;
      stk_rd_addr  = count_dec[SADDR_W-1:0];

      // configuration writes, taken in any state
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS: rows_req_in = csr_data;
            CSR_COLS: cols_req_in = csr_data;
            default:  rows_req_in = rows_req_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               perm_in = req_perm;
               if (req_cmd == CMD_START) begin
                  rows_used_in = side_fix(rows_req_ff);
                  cols_used_in = side_fix(cols_req_ff);
                  clr_in       = '0;
               end else if (count_ff == '0) begin
                  // step on an empty stack
                  carved_in   = 1'b0;
                  row_in      = '0;
                  col_in      = '0;
                  last_in     = 1'b1;
                  done_in     = 1'b1;
                  sec_pend_in = 1'b0;
               end
            end
         end
         ST_CLEAR: begin
            // sweep the visited map clear
            vis_wr_en = 1'b1;
            clr_in    = clr_ff + CELL_W'(1);
         end
         ST_SEED: begin
            // mark and push cell (1,1)
            vis_wr_en   = 1'b1;
            vis_wr_addr = '0;
            vis_wr_data = 1'b1;
            stk_wr_en   = 1'b1;
            stk_wr_addr = '0;
            stk_wr_data = '0;
            count_in    = CNT_W'(1);
            carved_in   = 1'b1;
            row_in      = SIDE_W'(1);
            col_in      = SIDE_W'(1);
            last_in     = 1'b1;
            done_in     = 1'b0;
            sec_pend_in = 1'b0;
         end
         ST_POP: begin
            stk_rd_en = 1'b1;
            count_in  = count_dec;
         end
         ST_TOP: begin
            top_in     = stk_rd_data;
            dir_idx_in = '0;
         end
         ST_LOOK: begin
            // probe one direction and read its visited bit
            vis_rd_en = 1'b1;
            nbr_in    = probe;
         end
         ST_TEST: begin
            if (!found) begin
               if (dir_idx_ff == 2'd3) begin
                  // backtrack
                  carved_in   = 1'b0;
                  row_in      = top_row;
                  col_in      = top_col;
                  last_in     = 1'b1;
                  done_in     = (count_ff == '0);
                  sec_pend_in = 1'b0;
               end else begin
                  dir_idx_in = dir_idx_ff + 2'd1;
               end
            end
         end
         ST_PUSH_CUR: begin
            // mark the neighbor, push back the popped cell
            vis_wr_en   = 1'b1;
            vis_wr_addr = nbr_ff.idx;
            vis_wr_data = 1'b1;
            stk_wr_en   = stk_has_room;
            stk_wr_data = top_ff;
            if (stk_has_room) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_PUSH_NEW: begin
            // push the neighbor, load wall result and hold the neighbor result
            stk_wr_en   = stk_has_room;
            stk_wr_data = nbr_ff.idx;
            if (stk_has_room) begin
               count_in = count_ff + CNT_W'(1);
            end
            carved_in   = 1'b1;
            row_in      = nbr_ff.wall_row;
            col_in      = nbr_ff.wall_col;
            last_in     = 1'b0;
            done_in     = 1'b0;
            sec_pend_in = 1'b1;
            sec_row_in  = nbr_ff.nb_row;
            sec_col_in  = nbr_ff.nb_col;
         end
         ST_SEND: begin
            if (rsp_fire && sec_pend_ff) begin
               carved_in   = 1'b1;
               row_in      = sec_row_ff;
               col_in      = sec_col_ff;
               last_in     = 1'b1;
               done_in     = 1'b0;
               sec_pend_in = 1'b0;
            end
         end
         default: begin
            vis_wr_en = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_req_ff  <= ROWS_REQ_RST;
         cols_req_ff  <= COLS_REQ_RST;
         rows_used_ff <= SIDE_MIN;
         cols_used_ff <= SIDE_MIN;
         count_ff     <= '0;
         sec_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_req_ff  <= rows_req_in;
         cols_req_ff  <= cols_req_in;
         rows_used_ff <= rows_used_in;
         cols_used_ff <= cols_used_in;
         count_ff     <= count_in;
         sec_pend_ff  <= sec_pend_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      clr_ff     <= clr_in;
      perm_ff    <= perm_in;
      top_ff     <= top_in;
      dir_idx_ff <= dir_idx_in;
      nbr_ff     <= nbr_in;
      carved_ff  <= carved_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
      sec_row_ff <= sec_row_in;
      sec_col_ff <= sec_col_in;
   end

   // checks
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a result is pending");

   a_first_of_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> sec_pend_ff)
      else $error("non-final result without a second result held");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_carve_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH_NEW) |-> (count_ff != '0))
      else $error("carve step left the stack empty");

endmodule

`default_nettype wire

[rtl/dmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Holds the visited map and the cell stack; no dependencies.
`default_nettype none

module dmc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/dmc_nbr.sv]
// Neighbor probe unit: one direction per use, gives wall cell, neighbor
// cell, bounds result and map index. Depends on dmc_pkg.
`default_nettype none

module dmc_nbr (
   input  wire logic [dmc_pkg::SIDE_W-1:0] cur_row,
   input  wire logic [dmc_pkg::SIDE_W-1:0] cur_col,
   input  wire dmc_pkg::dir_type           dir,
   input  wire logic [dmc_pkg::SIDE_W-1:0] rows_used,
   input  wire logic [dmc_pkg::SIDE_W-1:0] cols_used,
   output dmc_pkg::nbr_res_type            res
);
   import dmc_pkg::*;

   logic signed [SIDE_W+1:0] dr;
   logic signed [SIDE_W+1:0] dc;
   logic signed [SIDE_W+1:0] wr;
   logic signed [SIDE_W+1:0] wc;
   logic signed [SIDE_W+1:0] nr;
   logic signed [SIDE_W+1:0] nc;
   logic signed [SIDE_W+1:0] rlim;
   logic signed [SIDE_W+1:0] clim;

   // Unit step of the direction
   always_comb begin
      dr = '0;
      dc = '0;
      case (dir)
         DIR_RIGHT: dc = (SIDE_W+2)'(1);
         DIR_LEFT:  dc = -(SIDE_W+2)'(1);
         DIR_DOWN:  dr = (SIDE_W+2)'(1);
         DIR_UP:    dr = -(SIDE_W+2)'(1);
         default:   dr = '0;
      endcase
   end

   // Wall one step away, neighbor two steps away, interior bounds check
   always_comb begin
      wr   = $signed({2'b00, cur_row}) + dr;
      wc   = $signed({2'b00, cur_col}) + dc;
      nr   = wr + dr;
      nc   = wc + dc;
      rlim = $signed({2'b00, rows_used}) - (SIDE_W+2)'(1);
      clim = $signed({2'b00, cols_used}) - (SIDE_W+2)'(1);
      res.ok       = (nr > 0) && (nr < rlim) && (nc > 0) && (nc < clim);
      res.wall_row = wr[SIDE_W-1:0];
      res.wall_col = wc[SIDE_W-1:0];
      res.nb_row   = nr[SIDE_W-1:0];
      res.nb_col   = nc[SIDE_W-1:0];
      res.idx      = {nr[HALF_W:1], nc[HALF_W:1]};
   end

endmodule

`default_nettype wire

[test/dfs_maze_carver_top_tb.sv]
// Self-checking testbench for dfs_maze_carver_top: drives start and step items,
// predicts every carved or backtracked cell and checks the result stream.
// Depends on dmc_pkg and the dfs_maze_carver_top RTL only.
`timescale 1ns / 100ps

module dfs_maze_carver_top_tb;
   import dmc_pkg::*;

   localparam int GRID_HALF  = HALF_SIDE;
   localparam int SLOT_COUNT = CELL_SLOTS;
   localparam int PATH_LIMIT = STACK_DEPTH_DEF;
   localparam int PRINT_CAP  = 30;

   // Register indexes past the two grid registers; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic              carved;
      logic [SIDE_W-1:0] row;
      logic [SIDE_W-1:0] col;
      logic              last;
      logic              done;
   } carve_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = CMD_START;
   logic [PERM_W-1:0]    req_perm = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_carved;
   logic [SIDE_W-1:0]    rsp_cell_row;
   logic [SIDE_W-1:0]    rsp_cell_col;
   logic                 rsp_last;
   logic                 rsp_done_res;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIDE_W-1:0]    csr_data = '0;

   // Maze state as the block should hold it
   bit                  visited_cells [SLOT_COUNT];
   logic [CELL_W-1:0]   carve_path [$];
   logic [SIDE_W-1:0]   rows_req_m = ROWS_REQ_RST;
   logic [SIDE_W-1:0]   cols_req_m = COLS_REQ_RST;
   int                  rows_live = 3;
   int                  cols_live = 3;
   carve_result_type    expected_cells [$];

   int items_sent = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int snd_idle_pct = 8;
   int rsp_idle_pct = 63;
   int rsp_stall_req = 0;

   dfs_maze_carver_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_perm     (req_perm),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_carved   (rsp_carved),
      .rsp_cell_row (rsp_cell_row),
      .rsp_cell_col (rsp_cell_col),
      .rsp_last     (rsp_last),
      .rsp_done_res (rsp_done_res),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      #30_000_000;
      $display("dfs_maze_carver_top_tb: errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // Round a requested side up to odd, at least three
   function automatic int odd_side(input int v);
      if (v < 3) begin
         return 3;
      end
      return (v % 2 == 0) ? v + 1 : v;
   endfunction

   function automatic int slot_of(input int r, input int c);
      return ((r / 2) * GRID_HALF + c / 2) % SLOT_COUNT;
   endfunction

   // Drop the push when the stack is full
   function automatic void push_path(input int slot);
      if (carve_path.size() < PATH_LIMIT) begin
         carve_path.push_back(CELL_W'(slot));
      end
   endfunction

   function automatic void expect_cell(input bit carved, input int r, input int c,
                                       input bit last, input bit done);
      carve_result_type want;
      want.carved = carved;
      want.row    = SIDE_W'(r);
      want.col    = SIDE_W'(c);
      want.last   = last;
      want.done   = done;
      expected_cells.push_back(want);
   endfunction

   // Work out the cells that one accepted item carves or backtracks over
   function automatic void predict_carve(input logic cmd, input logic [PERM_W-1:0] perm);
      dir_type order [4];
      int      pool [4];
      int      fact [4];
      int      rest, pick, left, top, cr, cc, nr, nc, dr, dc, wall_r, wall_c, nslot;
      bit      found;
      if (cmd == CMD_START) begin
         rows_live = odd_side(rows_req_m);
         cols_live = odd_side(cols_req_m);
         visited_cells = '{default: 1'b0};
         carve_path.delete();
         visited_cells[slot_of(1, 1)] = 1'b1;
         push_path(slot_of(1, 1));
         expect_cell(1'b1, 1, 1, 1'b1, 1'b0);
      end else if (carve_path.size() == 0) begin
         expect_cell(1'b0, 0, 0, 1'b1, 1'b1);
      end else begin
         // decode the lexicographic index; out-of-range indexes mean index 0
         pool = '{0, 1, 2, 3};
         fact = '{6, 2, 1, 1};
         rest = (perm > 23) ? 0 : int'(perm);
         left = 4;
         for (int i = 0; i < 4; i++) begin
            pick = rest / fact[i];
            rest = rest % fact[i];
            order[i] = dir_type'(pool[pick]);
            for (int j = pick; j + 1 < left; j++) begin
               pool[j] = pool[j + 1];
            end
            left--;
         end
         top = carve_path.pop_back();
         cr = 2 * (top / GRID_HALF) + 1;
         cc = 2 * (top % GRID_HALF) + 1;
         found = 1'b0;
         nslot = 0;
         wall_r = 0;
         wall_c = 0;
         nr = 0;
         nc = 0;
         // take the first in-bounds unvisited neighbor two cells away
         for (int i = 0; i < 4; i++) begin
            case (order[i])
               DIR_RIGHT: begin dr = 0;  dc = 1;  end
               DIR_LEFT:  begin dr = 0;  dc = -1; end
               DIR_DOWN:  begin dr = 1;  dc = 0;  end
               default:   begin dr = -1; dc = 0;  end
            endcase
            if (!found && cr + 2 * dr > 0 && cr + 2 * dr < rows_live - 1 &&
                cc + 2 * dc > 0 && cc + 2 * dc < cols_live - 1 &&
                !visited_cells[slot_of(cr + 2 * dr, cc + 2 * dc)]) begin
               found = 1'b1;
               nr = cr + 2 * dr;
               nc = cc + 2 * dc;
               wall_r = cr + dr;
               wall_c = cc + dc;
               nslot = slot_of(nr, nc);
            end
         end
         if (found) begin
            visited_cells[nslot] = 1'b1;
            push_path(top);
            push_path(nslot);
            expect_cell(1'b1, wall_r, wall_c, 1'b0, 1'b0);
            expect_cell(1'b1, nr, nc, 1'b1, carve_path.size() == 0);
         end else begin
            expect_cell(1'b0, cr, cc, 1'b1, carve_path.size() == 0);
         end
      end
   endfunction

   function automatic logic [PERM_W-1:0] rand_perm();
      if ($urandom_range(99) < 85) begin
         return PERM_W'($urandom_range(23));
      end
      return PERM_W'($urandom_range(31, 24));
   endfunction

   // Offer one item, hold it until accepted, then predict its results
   task automatic send_item(input logic cmd, input logic [PERM_W-1:0] perm);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_perm  <= perm;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_carve(cmd, perm);
      items_sent++;
   endtask

   // Keep valid high when another write follows at once
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIDE_W-1:0] val,
                            input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_ROWS) begin
         rows_req_m = val;
      end else if (idx == CSR_COLS) begin
         cols_req_m = val;
      end
      if (!more) begin
         csr_valid <= 1'b0;
      end
   endtask

   task automatic set_grid(input int rows, input int cols, input bit more);
      write_csr(CSR_ROWS, SIDE_W'(rows), 1'b1);
      write_csr(CSR_COLS, SIDE_W'(cols), more);
   endtask

   // Pause the sender until every expected result has arrived
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_cells.size() != 0);
   endtask

   // Steps before any start see an empty stack
   task automatic test_empty_stack();
      send_item(CMD_STEP, 5'd0);
      send_item(CMD_STEP, 5'd31);
   endtask

   // Sides below three give a single-cell maze
   task automatic test_tiny_grid();
      wait_all_results();
      set_grid(0, 2, 1'b0);
      send_item(CMD_START, 5'd5);
      send_item(CMD_STEP, 5'd12);
      send_item(CMD_STEP, 5'd23);
      send_item(CMD_STEP, 5'd7);
   endtask

   // Largest grid, with permutation indexes past the table
   task automatic test_largest_grid();
      wait_all_results();
      set_grid(63, 62, 1'b0);
      send_item(CMD_START, 5'd31);
      send_item(CMD_STEP, 5'd23);
      send_item(CMD_STEP, 5'd24);
      send_item(CMD_STEP, 5'd31);
      send_item(CMD_STEP, 5'd16);
      send_item(CMD_STEP, 5'd0);
      send_item(CMD_STEP, 5'd7);
   endtask

   // Writes to the spare indexes must not touch the grid size
   task automatic test_spare_csr();
      wait_all_results();
      set_grid(4, 3, 1'b1);
      write_csr(CSR_SPARE_A, 6'd1, 1'b1);
      write_csr(CSR_SPARE_B, 6'd63, 1'b0);
      send_item(CMD_START, 5'd18);
      send_item(CMD_STEP, 5'd18);
      send_item(CMD_STEP, 5'd9);
      send_item(CMD_STEP, 5'd2);
   endtask

   // Stall the receiver long enough that the block stops taking items
   task automatic test_backpressure();
      wait_all_results();
      set_grid(15, 15, 1'b0);
      send_item(CMD_START, 5'd0);
      // let the map sweep finish so the stall lands on step results
      wait_all_results();
      rsp_stall_req = 400;
      repeat (15) send_item(CMD_STEP, rand_perm());
      wait_all_results();
   endtask

   // Mazes on random grids, carved for at most 80 steps each with restarts as noise, then up to two extra steps
   task automatic test_random_mazes(input int snd_pct, input int rcv_pct, input int quota);
      int goal, rows, cols, steps, sel;
      snd_idle_pct = snd_pct;
      rsp_idle_pct = rcv_pct;
      goal = items_sent + quota;
      while (items_sent < goal) begin
         sel = $urandom_range(99);
         if (sel < 60) begin
            rows = $urandom_range(11, 0);
            cols = $urandom_range(11, 0);
         end else if (sel < 90) begin
            rows = $urandom_range(31, 12);
            cols = $urandom_range(31, 1);
         end else begin
            rows = $urandom_range(63, 32);
            cols = $urandom_range(63, 32);
         end
         wait_all_results();
         set_grid(rows, cols, 1'b0);
         send_item(CMD_START, rand_perm());
         steps = 0;
         while (carve_path.size() > 0 && steps < 80) begin
            if ($urandom_range(99) < 2) begin
               send_item(CMD_START, rand_perm());
            end else begin
               send_item(CMD_STEP, rand_perm());
            end
            steps++;
         end
         repeat ($urandom_range(2)) send_item(CMD_STEP, rand_perm());
      end
   endtask

   // Drive the result ready: random idling, plus long stalls on request
   initial begin : rsp_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_stall_req > 0) begin
            stall_left = rsp_stall_req;
            rsp_stall_req = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : rsp_check
      carve_result_type got, want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got.carved = rsp_carved;
         got.row    = rsp_cell_row;
         got.col    = rsp_cell_col;
         got.last   = rsp_last;
         got.done   = rsp_done_res;
         if (expected_cells.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
         end else begin
            want = expected_cells.pop_front();
            if (got.carved !== want.carved)
               report_mismatch($sformatf("result %0d carved: got %b want %b",
                                         results_seen, got.carved, want.carved));
            if (got.row !== want.row)
               report_mismatch($sformatf("result %0d cell_row: got %0d want %0d",
                                         results_seen, got.row, want.row));
            if (got.col !== want.col)
               report_mismatch($sformatf("result %0d cell_col: got %0d want %0d",
                                         results_seen, got.col, want.col));
            if (got.last !== want.last)
               report_mismatch($sformatf("result %0d last: got %b want %b",
                                         results_seen, got.last, want.last));
            if (got.done !== want.done)
               report_mismatch($sformatf("result %0d done_res: got %b want %b",
                                         results_seen, got.done, want.done));
         end
         results_seen++;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack();
      test_tiny_grid();
      test_largest_grid();
      test_spare_csr();
      test_backpressure();
      test_random_mazes(8, 63, 195);
      test_random_mazes(63, 8, 195);
      test_random_mazes(0, 0, 195);
      wait_all_results();
      repeat (16) @(posedge clock);
      if (expected_cells.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_cells.size()));
      end
      if (mismatch_count == 0) begin
         $display("dfs_maze_carver_top_tb: clean");
      end else begin
         $display("dfs_maze_carver_top_tb: errors");
      end
      $finish;
   end

endmodule
